// ----- hdl/tlpb_pkg.sv -----
// Package for the two-level priority bitmap: map geometry, operation codes
// and the two priority encoders shared by the datapath.
// No dependencies.
package tlpb_pkg;

  localparam int WordBits = 8;
  localparam int NumWords = 8;

  localparam int OpW     = 2;
  localparam int LevelW  = 6;
  localparam int ResultW = 7;

  localparam int BitW    = $clog2(WordBits);
  localparam int WidxW   = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BitCntW = $clog2(WordBits + 1);
  localparam int ResW    = $clog2(NumWords * WordBits + 1);

  typedef enum logic [OpW-1:0] {
    OpSet   = 2'd0,
    OpClear = 2'd1,
    OpQuery = 2'd2
  } opcode_e;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [NumWords-1:0] summary_t;

  // Index of the highest set bit plus one, zero for an empty word.
  function automatic logic [BitCntW-1:0] word_top(word_t v);
    logic [BitCntW-1:0] r;
    r = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (v[i]) r = BitCntW'(i + 1);
    end
    return r;
  endfunction

  // Index of the highest non-empty word; only meaningful if s is non-zero.
  function automatic logic [WidxW-1:0] summary_top(summary_t s);
    logic [WidxW-1:0] r;
    r = '0;
    for (int i = 0; i < NumWords; i++) begin
      if (s[i]) r = WidxW'(i);
    end
    return r;
  endfunction

endpackage

// ----- hdl/two_level_priority_bitmap_top.sv -----
// Two-level priority bitmap: scheduler ready map with a word store in a
// synchronous memory and a summary word in flip-flops.
// Depends on tlpb_pkg.
//
// Usage
//   Request channel: in_valid_i/in_ready_o carrying opcode_i (set, clear,
//   query; code 3 acts as query) and level_i. Levels beyond the map are
//   not stored but still produce a result.
//   Result channel: out_valid_o/out_ready_i carrying highest_plus_one_o,
//   the highest set level plus one after the request, 0 for an empty map.
//   One result per request, in order.
//   Sequence: a request passes through a word read, a read-modify-write
//   with the read of the top word, then priority encoding into the output
//   register. The word memory port sets this. A new request is taken only
//   once the previous one has loaded the output register, which waits
//   until the output is drained.
//   Stalls: the output register holds a finished result; the next request
//   is accepted while it waits, but its own result waits until the
//   receiver takes the earlier one.
//   Reset: the summary word and the per-word valid bits clear at once, so
//   the whole map reads as empty straight after reset; no clearing pass.
module two_level_priority_bitmap_top
  import tlpb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [LevelW-1:0]  level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ResultW-1:0] highest_plus_one_o
);

  typedef enum logic [1:0] {
    SIdle,
    SModify,
    SResult
  } state_e;

  state_e               state_q;
  logic [OpW-1:0]       op_q;
  logic [WidxW-1:0]     widx_q;
  logic [BitW-1:0]      bit_q;
  logic                 in_range_q;
  summary_t             summary_q, summary_d;
  logic [NumWords-1:0]  vld_q;
  logic [WidxW-1:0]     top_q, top_d;
  logic                 any_q;
  logic                 fwd_q;
  word_t                fwd_word_q;
  logic                 out_valid_q;
  logic [ResultW-1:0]   out_q;

  // word memory
  word_t                mem_q [NumWords];
  word_t                rdata_q;
  logic                 rd_en;
  logic [WidxW-1:0]     rd_addr;
  logic                 wr_en;
  word_t                wr_data;

  logic                 accept;
  logic [LevelW:0]      lvl_ext;
  logic [LevelW:0]      widx_full;
  logic [LevelW:0]      bit_full;
  logic                 in_range;
  word_t                old_word;
  word_t                res_word;
  logic [ResW-1:0]      result;
  logic                 out_free;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SIdle);
  assign out_free  = !out_valid_q || out_ready_i;

  assign lvl_ext   = {1'b0, level_i};
  assign widx_full = (LevelW + 1)'(lvl_ext / WordBits);
  assign bit_full  = (LevelW + 1)'(lvl_ext % WordBits);
  assign in_range  = (widx_full < (LevelW + 1)'(NumWords));

  // read-modify-write of the addressed word
  assign old_word = vld_q[widx_q] ? rdata_q : '0;

  always_comb begin
    wr_en     = 1'b0;
    wr_data   = old_word;
    summary_d = summary_q;
    if (state_q == SModify && in_range_q) begin
      case (opcode_e'(op_q))
        OpSet: begin
          wr_en             = 1'b1;
          wr_data           = old_word | (word_t'(1) << bit_q);
          summary_d[widx_q] = 1'b1;
        end
        OpClear: begin
          wr_en   = 1'b1;
          wr_data = old_word & ~(word_t'(1) << bit_q);
          if (wr_data == '0) summary_d[widx_q] = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign top_d = summary_top(summary_d);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_q == SIdle && accept) begin
      rd_en   = 1'b1;
      rd_addr = in_range ? WidxW'(widx_full) : '0;
    end else if (state_q == SModify) begin
      rd_en   = 1'b1;
      rd_addr = top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[widx_q] <= wr_data;
  end

  // read-first: a same-entry write in the modify cycle is forwarded instead
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  assign res_word = fwd_q ? fwd_word_q : (vld_q[top_q] ? rdata_q : '0);

  always_comb begin
    result = '0;
    if (any_q) begin
      result = ResW'(word_top(res_word)) + ResW'(top_q) * ResW'(WordBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      summary_q   <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      widx_q      <= '0;
      bit_q       <= '0;
      in_range_q  <= 1'b0;
      top_q       <= '0;
      any_q       <= 1'b0;
      fwd_q       <= 1'b0;
      fwd_word_q  <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (accept) begin
            op_q       <= opcode_i;
            widx_q     <= WidxW'(widx_full);
            bit_q      <= BitW'(bit_full);
            in_range_q <= in_range;
            state_q    <= SModify;
          end
        end
        SModify: begin
          summary_q  <= summary_d;
          if (wr_en) vld_q[widx_q] <= 1'b1;
          top_q      <= top_d;
          any_q      <= |summary_d;
          fwd_q      <= wr_en && (top_d == widx_q);
          fwd_word_q <= wr_data;
          state_q    <= SResult;
        end
        SResult: begin
          if (out_free) begin
            out_q       <= ResultW'(result);
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign highest_plus_one_o = out_q;

endmodule

// ----- hdl/tlpb_checker.sv -----
// Port-level checker for the two-level priority bitmap, bound to the top.
// Depends on tlpb_pkg and two_level_priority_bitmap_top.
module tlpb_checker
  import tlpb_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ResultW-1:0] highest_plus_one_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(highest_plus_one_o))
    else $error("result changed or dropped while stalled");

  // result never exceeds the number of levels
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (highest_plus_one_o <= ResultW'(NumWords * WordBits)))
    else $error("result beyond the map");

  // a request holds off new requests through its modify and result states
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken during a read-modify-write");

  // a fresh result only appears as a request completes
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised without completing a request");

endmodule

bind two_level_priority_bitmap_top tlpb_checker u_tlpb_checker (.*);
